/* sv/pib_pkg.sv */
`timescale 1ns / 1ps
package pib_pkg;

    localparam int NUM_COORDS = 4;
    localparam int COORD_W    = 64;

    localparam logic [1:0] CMD_EXTENT = 2'd0;
    localparam logic [1:0] CMD_STEP   = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] CFG_NUM_DIMS     = 2'd0;
    localparam logic [1:0] CFG_SINGLE_STEP  = 2'd1;
    localparam logic [1:0] CFG_TOTAL_BLOCKS = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         entry_index;
        logic [1:0]         dim_index;
        logic [COORD_W-1:0] extent_start;
        logic [COORD_W-1:0] extent_count;
        logic [5:0]         query_step;
        logic [COORD_W-1:0] coord_0;
        logic [COORD_W-1:0] coord_1;
        logic [COORD_W-1:0] coord_2;
        logic [COORD_W-1:0] coord_3;
    } in_t;

    typedef struct packed {
        logic       found;
        logic [7:0] block_number;
    } out_t;

    typedef struct packed {
        logic               en;
        logic [COORD_W-1:0] start;
        logic [COORD_W-1:0] count;
    } cell_wr_t;

endpackage

/* sv/pib_cell.sv */
`timescale 1ns / 1ps
module pib_cell #(
    parameter int ABW = 8
) (
    input  logic                        clk,
    input  pib_pkg::cell_wr_t           wr,
    input  logic [ABW-1:0]              wr_addr,
    input  logic [ABW-1:0]              rd_addr,
    input  logic [pib_pkg::COORD_W-1:0] coord,
    input  logic                        active,
    input  logic                        match_in,
    output logic                        match_out
);
    import pib_pkg::*;

    localparam int DEPTH = 1 << ABW;

    logic [COORD_W-1:0] start_mem [DEPTH];
    logic [COORD_W-1:0] count_mem [DEPTH];
    logic [COORD_W-1:0] start_reg;
    logic [COORD_W-1:0] count_reg;
    logic [COORD_W-1:0] diff;
    logic               holds;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            start_mem[wr_addr] <= wr.start;
            count_mem[wr_addr] <= wr.count;
        end
        start_reg <= start_mem[rd_addr];
        count_reg <= count_mem[rd_addr];
    end

    // half-open interval test without forming start + count
    assign diff      = coord - start_reg;
    assign holds     = (coord >= start_reg) && (diff < count_reg);
    assign match_out = match_in && (!active || holds);

endmodule

/* sv/point_in_block_box_lookup_top.sv */
`timescale 1ns / 1ps
// channel  | signals                               | transaction at
// item     | start, busy, item                     | start & !busy
// result   | done, result                          | done (one cycle)
// config   | cfg_valid, cfg_ready, cfg_index/data  | cfg_valid & cfg_ready
//
// loads leave busy low
// a multi-step query first reads the step counts of steps 0 to query_step and sums the earlier ones
// the scan reads the blocks in order through the single read port of each dimension's box memory
// and stops at the first match; done is then registered in the final state
// reset clears control and sets configuration to its defaults; box and step tables are undefined until written
// the receiver cannot stall: done is high for exactly one cycle
module point_in_block_box_lookup_top #(
    parameter int MAX_BLOCKS = 256,
    parameter int MAX_DIMS   = 4,
    parameter int MAX_STEPS  = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pib_pkg::in_t  item,
    output logic          done,
    output pib_pkg::out_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import pib_pkg::*;

    localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int BASEW = $clog2(MAX_STEPS * MAX_BLOCKS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SUM, S_SCAN, S_FIN} state_t;

    state_t             state_reg;
    logic [2:0]         num_dims_reg;
    logic               single_reg;
    logic [8:0]         total_reg;
    logic [SW-1:0]      s_reg;
    logic               sum_issue_reg;
    logic               sum_pend_reg;
    logic [SW-1:0]      sum_pidx_reg;
    logic [SW-1:0]      qstep_reg;
    logic [BASEW-1:0]   base_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      i_reg;
    logic               scan_pend_reg;
    logic [CW-1:0]      rel_pend_reg;
    logic               found_reg;
    logic [CW-1:0]      rel_reg;
    logic               done_reg;
    out_t               result_reg;
    logic [COORD_W-1:0] coord_reg [NUM_COORDS];

    logic [CW-1:0]      step_mem [1 << SW];
    logic [CW-1:0]      step_rdata_reg;

    logic               accept;
    logic [31:0]        ent32;
    logic [31:0]        lim32;
    logic [31:0]        nd32;
    logic [CW-1:0]      limit;
    logic [BASEW:0]     abs_idx;
    logic               can_issue;
    logic [BW-1:0]      blk_addr;
    logic [MAX_DIMS:0]  chain;
    logic               step_wr;
    logic [CW-1:0]      step_wval;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign ent32 = 32'(item.entry_index);
    assign lim32 = (32'(total_reg) > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS) : 32'(total_reg);
    assign limit = CW'(lim32);

    always_comb
    begin
        nd32 = 32'(num_dims_reg);
        if (nd32 > 32'(MAX_DIMS))
            nd32 = 32'(MAX_DIMS);
        if (nd32 > 32'(NUM_COORDS))
            nd32 = 32'(NUM_COORDS);
    end

    assign abs_idx   = {1'b0, base_reg} + (BASEW + 1)'(i_reg);
    assign can_issue = (i_reg < cnt_reg) && (abs_idx < (BASEW + 1)'(limit));
    assign blk_addr  = abs_idx[BW-1:0];

    // step count table
    assign step_wr   = accept && (item.cmd == CMD_STEP) && (ent32 < 32'(MAX_STEPS));
    assign step_wval = (item.extent_count > 64'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                              : CW'(item.extent_count);

    always_ff @(posedge clk)
    begin
        if (step_wr)
            step_mem[ent32[SW-1:0]] <= step_wval;
        step_rdata_reg <= step_mem[s_reg];
    end

    // one cell per dimension, match flag handed along the row
    assign chain[0] = (nd32 != 32'd0);

    genvar d;
    generate
        for (d = 0; d < MAX_DIMS; d++)
        begin : g_cell
            cell_wr_t           wr;
            logic [COORD_W-1:0] cd;
            assign wr.en    = accept && (item.cmd == CMD_EXTENT)
                              && (ent32 < 32'(MAX_BLOCKS))
                              && (32'(item.dim_index) == d);
            assign wr.start = item.extent_start;
            assign wr.count = item.extent_count;
            if (d < NUM_COORDS)
            begin : g_c
                assign cd = coord_reg[d];
            end
            else
            begin : g_z
                assign cd = '0;
            end
            pib_cell #(.ABW(BW)) u_cell (
                .clk       (clk),
                .wr        (wr),
                .wr_addr   (ent32[BW-1:0]),
                .rd_addr   (blk_addr),
                .coord     (cd),
                .active    (32'(d) < nd32),
                .match_in  (chain[d]),
                .match_out (chain[d+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (accept && (item.cmd == CMD_QUERY))
        begin
            coord_reg[0] <= item.coord_0;
            coord_reg[1] <= item.coord_1;
            coord_reg[2] <= item.coord_2;
            coord_reg[3] <= item.coord_3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_dims_reg  <= 3'd1;
            single_reg    <= 1'b1;
            total_reg     <= 9'd0;
            s_reg         <= '0;
            sum_issue_reg <= 1'b0;
            sum_pend_reg  <= 1'b0;
            sum_pidx_reg  <= '0;
            qstep_reg     <= '0;
            base_reg      <= '0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            scan_pend_reg <= 1'b0;
            rel_pend_reg  <= '0;
            found_reg     <= 1'b0;
            rel_reg       <= '0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_NUM_DIMS:     num_dims_reg <= cfg_data[2:0];
                    CFG_SINGLE_STEP:  single_reg   <= cfg_data[0];
                    CFG_TOTAL_BLOCKS: total_reg    <= cfg_data[8:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (item.cmd == CMD_QUERY))
                    begin
                        found_reg     <= 1'b0;
                        rel_reg       <= '0;
                        i_reg         <= '0;
                        base_reg      <= '0;
                        scan_pend_reg <= 1'b0;
                        sum_pend_reg  <= 1'b0;
                        s_reg         <= '0;
                        if (single_reg)
                        begin
                            cnt_reg   <= limit;
                            state_reg <= S_SCAN;
                        end
                        else if (32'(item.query_step) < 32'(MAX_STEPS))
                        begin
                            qstep_reg     <= SW'(item.query_step);
                            sum_issue_reg <= 1'b1;
                            state_reg     <= S_SUM;
                        end
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_SUM:
                begin
                    sum_pend_reg <= sum_issue_reg;
                    sum_pidx_reg <= s_reg;
                    if (sum_issue_reg)
                    begin
                        if (s_reg == qstep_reg)
                            sum_issue_reg <= 1'b0;
                        else
                            s_reg <= s_reg + SW'(1);
                    end
                    if (sum_pend_reg)
                    begin
                        if (sum_pidx_reg == qstep_reg)
                        begin
                            cnt_reg   <= step_rdata_reg;
                            state_reg <= S_SCAN;
                        end
                        else
                            base_reg <= base_reg + BASEW'(step_rdata_reg);
                    end
                end
                S_SCAN:
                begin
                    if (scan_pend_reg && chain[MAX_DIMS])
                    begin
                        found_reg <= 1'b1;
                        rel_reg   <= rel_pend_reg;
                        state_reg <= S_FIN;
                    end
                    else if (can_issue)
                    begin
                        scan_pend_reg <= 1'b1;
                        rel_pend_reg  <= i_reg;
                        i_reg         <= i_reg + CW'(1);
                    end
                    else if (scan_pend_reg)
                        scan_pend_reg <= 1'b0;
                    else
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    done_reg                <= 1'b1;
                    result_reg.found        <= found_reg;
                    result_reg.block_number <= found_reg ? 8'(rel_reg) : 8'd0;
                    state_reg               <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* sv/pib_checker.sv */
`timescale 1ns / 1ps
module pib_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input pib_pkg::in_t  item,
    input logic          done,
    input pib_pkg::out_t result
);
    import pib_pkg::*;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a query in progress");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.block_number == 8'd0))
        else $error("block number not zero on a miss");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.cmd == CMD_QUERY) |=> busy)
        else $error("query transaction did not raise busy");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.cmd != CMD_QUERY) |=> (!busy && !done))
        else $error("load transaction gave busy or a result");

endmodule

bind point_in_block_box_lookup_top pib_checker u_pib_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import pib_pkg::*;

    localparam int N_BLOCKS = 256;
    localparam int N_DIMS   = 4;
    localparam int N_STEPS  = 64;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_t         item;
    logic        done;
    out_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    point_in_block_box_lookup_top #(
        .MAX_BLOCKS(N_BLOCKS),
        .MAX_DIMS  (N_DIMS),
        .MAX_STEPS (N_STEPS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // mirror of the block's tables and registers
    logic [63:0] box_lo  [N_BLOCKS][N_DIMS];
    logic [63:0] box_len [N_BLOCKS][N_DIMS];
    int          step_len[N_STEPS];
    int          dims_reg;
    bit          single_reg;
    int          total_reg;

    out_t        pending_hits[$];
    int          errors;
    int          sender_idle_pct;

    always #5 clk = ~clk;

    function automatic bit box_contains(int blk, logic [63:0] pt[4], int nd);
        if (nd == 0)
            return 0;
        for (int d = 0; d < nd; d++)
        begin
            if (pt[d] < box_lo[blk][d] || (pt[d] - box_lo[blk][d]) >= box_len[blk][d])
                return 0;
        end
        return 1;
    endfunction

    function automatic void lookup_predict(input in_t it, output bit gives, output out_t r);
        logic [63:0] pt[4];
        int          nd;
        int          lim;
        int          base;
        gives = 0;
        r     = '0;
        pt[0] = it.coord_0;
        pt[1] = it.coord_1;
        pt[2] = it.coord_2;
        pt[3] = it.coord_3;
        if (it.cmd == CMD_EXTENT)
        begin
            box_lo[it.entry_index][it.dim_index]  = it.extent_start;
            box_len[it.entry_index][it.dim_index] = it.extent_count;
        end
        else if (it.cmd == CMD_STEP)
        begin
            if (it.entry_index < N_STEPS)
                step_len[it.entry_index] = (it.extent_count > N_BLOCKS) ? N_BLOCKS
                                         : int'(it.extent_count);
        end
        else if (it.cmd == CMD_QUERY)
        begin
            gives = 1;
            nd    = (dims_reg > N_DIMS) ? N_DIMS : dims_reg;
            lim   = (total_reg > N_BLOCKS) ? N_BLOCKS : total_reg;
            if (single_reg)
            begin
                for (int i = 0; i < lim; i++)
                begin
                    if (box_contains(i, pt, nd))
                    begin
                        r.found        = 1;
                        r.block_number = i[7:0];
                        break;
                    end
                end
            end
            else
            begin
                base = 0;
                for (int s = 0; s < it.query_step; s++)
                    base += step_len[s];
                for (int i = 0; i < step_len[it.query_step]; i++)
                begin
                    if (base + i >= lim)
                        break;
                    if (box_contains(base + i, pt, nd))
                    begin
                        r.found        = 1;
                        r.block_number = i[7:0];
                        break;
                    end
                end
            end
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%t: unexpected result, expected none, actual found=%0d block=%0d",
                         $time, result.found, result.block_number);
                errors++;
            end
            else
            begin
                if (result.found !== pending_hits[0].found)
                begin
                    $display("%t: found mismatch, expected %0d, actual %0d",
                             $time, pending_hits[0].found, result.found);
                    errors++;
                end
                if (result.block_number !== pending_hits[0].block_number)
                begin
                    $display("%t: block_number mismatch, expected %0d, actual %0d",
                             $time, pending_hits[0].block_number, result.block_number);
                    errors++;
                end
                void'(pending_hits.pop_front());
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input in_t it);
        bit   gives;
        out_t r;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start = 0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start = 1;
        item  = it;
        do
            @(posedge clk);
        while (busy);
        lookup_predict(it, gives, r);
        if (gives)
            pending_hits.push_back(r);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start = 0;
        while (pending_hits.size() != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = val[15:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_NUM_DIMS)
            dims_reg = val & 7;
        else if (idx == CFG_SINGLE_STEP)
            single_reg = val[0];
        else if (idx == CFG_TOTAL_BLOCKS)
            total_reg = val & 511;
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic set_config(input int nd, input int mode, input int total);
        drain_results();
        write_reg(CFG_NUM_DIMS, nd);
        write_reg(CFG_SINGLE_STEP, mode);
        write_reg(CFG_TOTAL_BLOCKS, total);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_t make_extent(int blk, int d, logic [63:0] s, logic [63:0] c);
        in_t it;
        it              = '0;
        it.cmd          = CMD_EXTENT;
        it.entry_index  = blk[7:0];
        it.dim_index    = d[1:0];
        it.extent_start = s;
        it.extent_count = c;
        it.coord_0      = rand64();
        return it;
    endfunction

    function automatic in_t make_step(int st, logic [63:0] c);
        in_t it;
        it              = '0;
        it.cmd          = CMD_STEP;
        it.entry_index  = st[7:0];
        it.extent_count = c;
        return it;
    endfunction

    function automatic in_t make_query(int st, logic [63:0] c0, logic [63:0] c1,
                                       logic [63:0] c2, logic [63:0] c3);
        in_t it;
        it            = '0;
        it.cmd        = CMD_QUERY;
        it.query_step = st[5:0];
        it.coord_0    = c0;
        it.coord_1    = c1;
        it.coord_2    = c2;
        it.coord_3    = c3;
        return it;
    endfunction

    function automatic logic [63:0] inside_coord(int blk, int d);
        if (box_len[blk][d] == 0)
            return box_lo[blk][d];
        return box_lo[blk][d] + (rand64() % box_len[blk][d]);
    endfunction

    function automatic in_t make_hit_query(int blk);
        int st;
        int acc;
        st  = 0;
        acc = 0;
        while (st < N_STEPS - 1 && acc + step_len[st] <= blk)
        begin
            acc += step_len[st];
            st++;
        end
        return make_query(st, inside_coord(blk, 0), inside_coord(blk, 1),
                          inside_coord(blk, 2), inside_coord(blk, 3));
    endfunction

    task automatic test_table_fill();
        logic [63:0] s;
        for (int b = 0; b < N_BLOCKS; b++)
        begin
            for (int d = 0; d < N_DIMS; d++)
            begin
                s = 64'(b * 10 + $urandom_range(0, 30));
                send_item(make_extent(b, d, s, 64'($urandom_range(0, 40))));
            end
        end
        for (int st = 0; st < N_STEPS; st++)
            send_item(make_step(st, 64'd4));
    endtask

    task automatic test_directed();
        in_t it;
        set_config(4, 1, 256);
        // box at the top of the coordinate range
        send_item(make_extent(0, 0, '1, '1));
        send_item(make_extent(0, 1, '0, '1));
        send_item(make_extent(0, 2, '0, '1));
        send_item(make_extent(0, 3, '0, '1));
        send_item(make_query(0, '1, '1 - 1, 0, 5));
        send_item(make_query(0, '1, '1, 0, 5));
        send_item(make_query(0, '1 - 1, 0, 0, 0));
        // empty box never matches
        send_item(make_extent(1, 0, 64'd100, 64'd0));
        send_item(make_query(0, 64'd100, 0, 0, 0));
        send_item(make_hit_query(200));
        // unused command
        it          = make_query(0, 0, 0, 0, 0);
        it.cmd      = CMD_UNUSED;
        it.entry_index = '1;
        send_item(it);
        // step count saturation, step table edges
        send_item(make_step(0, '1));
        send_item(make_step(255, 64'd3));
        set_config(4, 0, 256);
        send_item(make_hit_query(3));
        send_item(make_query(63, '1, '1, '1, '1));
        send_item(make_step(0, 64'd4));
        send_item(make_hit_query(100));
        send_item(make_hit_query(255));
        send_item(make_query(63, 0, 0, 0, 0));
        set_config(0, 1, 256);
        send_item(make_hit_query(10));
        set_config(7, 0, 511);
        send_item(make_hit_query(50));
        set_config(1, 1, 0);
        send_item(make_hit_query(0));
    endtask

    task automatic test_random(input int count);
        int k;
        int b;
        int nd;
        int mode;
        int total;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
            begin
                case ($urandom_range(0, 5))
                    0: nd = 0;
                    1: nd = 1;
                    2: nd = 4;
                    3: nd = 7;
                    default: nd = $urandom_range(1, 4);
                endcase
                mode = $urandom_range(0, 1);
                case ($urandom_range(0, 4))
                    0: total = 0;
                    1: total = 256;
                    2: total = 511;
                    default: total = $urandom_range(1, 300);
                endcase
                set_config(nd, mode, total);
            end
            if (n == count / 2)
                drain_results();
            if (n == count / 3)
                sender_idle_pct = 50;
            if (n == (2 * count) / 3)
                sender_idle_pct = 0;
            k = $urandom_range(99);
            b = $urandom_range(0, N_BLOCKS - 1);
            if (k < 55)
                send_item(make_hit_query(b));
            else if (k < 65)
                send_item(make_query($urandom_range(0, 63), rand64(), rand64(),
                                     rand64(), rand64()));
            else if (k < 80)
                send_item(make_extent(b, $urandom_range(0, 3),
                                      64'(b * 10 + $urandom_range(0, 30)),
                                      ($urandom_range(0, 9) == 0) ? rand64()
                                      : 64'($urandom_range(0, 40))));
            else if (k < 85)
                send_item(make_extent(b, $urandom_range(0, 3), rand64(), rand64()));
            else if (k < 95)
                send_item(make_step($urandom_range(0, 255),
                                    ($urandom_range(0, 4) == 0) ? rand64()
                                    : 64'($urandom_range(0, 8))));
            else
            begin
                send_item(make_query(0, rand64(), 0, 0, 0));
            end
        end
    endtask

    initial
    begin
        clk             = 0;
        rst_n           = 0;
        start           = 0;
        item            = '0;
        cfg_valid       = 0;
        cfg_index       = '0;
        cfg_data        = '0;
        errors          = 0;
        sender_idle_pct = 17;
        dims_reg        = 1;
        single_reg      = 1;
        total_reg       = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (2) @(negedge clk);
        test_table_fill();
        test_directed();
        test_random(840);
        drain_results();
        repeat (400) @(negedge clk);
        if (errors == 0 && pending_hits.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
